// ===== hdl/nst_pkg.sv =====
package nst_pkg;

   localparam int BIN_W   = 11;
   localparam int POWER_W = 32;
   localparam int PROB_W  = 17;
   localparam int GAIN_W  = 8;
   localparam int CSR_W   = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int PIPE_DEPTH  = 8;

   typedef struct packed {
      logic [BIN_W-1:0]   bin;
      logic [POWER_W-1:0] power;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]   out_bin;
      logic [POWER_W-1:0] noise_estimate;
      logic [PROB_W-1:0]  speech_prob;
      logic               speech_present;
   } rsp_type;

   typedef struct packed {
      logic [POWER_W-1:0] smooth;
      logic [POWER_W-1:0] minimum;
      logic [PROB_W-1:0]  presence;
      logic [POWER_W-1:0] noise;
   } state_type;

   localparam int STATE_W = $bits(state_type);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOW_EDGE  = 3'd0,
      CSR_MID_EDGE  = 3'd1,
      CSR_LOW_GAIN  = 3'd2,
      CSR_MID_GAIN  = 3'd3,
      CSR_HIGH_GAIN = 3'd4
   } csr_index_type;

   localparam logic [BIN_W-1:0]  RESET_LOW_EDGE  = 11'd43;
   localparam logic [BIN_W-1:0]  RESET_MID_EDGE  = 11'd128;
   localparam logic [GAIN_W-1:0] RESET_LOW_GAIN  = 8'd32;
   localparam logic [GAIN_W-1:0] RESET_MID_GAIN  = 8'd32;
   localparam logic [GAIN_W-1:0] RESET_HIGH_GAIN = 8'd112;

   localparam logic [15:0] C_SMOOTH_PREV = 16'd45875;
   localparam logic [15:0] C_SMOOTH_CUR  = 16'd19661;
   localparam logic [15:0] C_GAMMA       = 16'd65405;
   localparam logic signed [11:0] C_MIN_GAIN = 12'sd655;
   localparam logic [15:0] C_BETA        = 16'd52429;
   localparam logic [15:0] C_AP_PREV     = 16'd13107;
   localparam logic [PROB_W-1:0] C_AP_CUR   = 17'd52429;
   localparam logic [PROB_W-1:0] C_AD_BASE  = 17'd62259;
   localparam logic [11:0]       C_AD_SLOPE = 12'd3277;
   localparam logic [PROB_W-1:0] PROB_ONE   = 17'd65536;

endpackage

// ===== hdl/nst_ram.sv =====
module nst_ram #(
   parameter int WIDTH = 113,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/nst_update.sv =====
module nst_update (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     issue,
   input  logic                     issue_in_range,
   input  nst_pkg::req_type         issue_req,
   input  logic [7:0]               issue_gain,
   input  nst_pkg::state_type       rd_data,
   input  logic [10:0]              probe_bin,
   output logic                     probe_hit,
   output logic                     wr_en,
   output logic [10:0]              wr_bin,
   output nst_pkg::state_type       wr_data,
   output logic                     res_valid,
   output nst_pkg::rsp_type         res
);

   import nst_pkg::*;

   // stage tags
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [PIPE_DEPTH-1:0] inr_ff, inr_in;
   logic [BIN_W-1:0]      bin_ff [PIPE_DEPTH];
   logic [BIN_W-1:0]      bin_in [PIPE_DEPTH];

   // stage 0
   logic [POWER_W-1:0] pwr0_ff;
   logic [GAIN_W-1:0]  gain0_ff;

   // stage 1
   logic [47:0] m_sp1_ff, m_sp1_in, m_pw1_ff, m_pw1_in, m_bt1_ff, m_bt1_in;
   logic [47:0] m_gm1_ff, m_gm1_in;
   logic [32:0] m_ap1_ff, m_ap1_in;
   logic [POWER_W-1:0] min1_ff, noise1_ff, pwr1_ff;
   logic [GAIN_W-1:0]  gain1_ff;

   // stage 2
   logic [47:0]        s_sum;
   logic [POWER_W-1:0] s2_ff, s2_in, beta2_ff, beta2_in, min2_ff, noise2_ff, pwr2_ff;
   logic [PROB_W-1:0]  ph2_ff, ph2_in;
   logic [47:0]        m_gm2_ff;
   logic [GAIN_W-1:0]  gain2_ff;

   // stage 3
   logic signed [32:0] d3;
   logic signed [43:0] md3_ff, md3_in;
   logic               rise3_ff, rise3_in;
   logic [POWER_W-1:0] s3_ff, noise3_ff, pwr3_ff;
   logic [PROB_W-1:0]  ph3_ff;
   logic [47:0]        m_gm3_ff;
   logic [GAIN_W-1:0]  gain3_ff;

   // stage 4
   logic signed [49:0] v4;
   logic [POWER_W-1:0] mn4_ff, mn4_in, s4_ff, noise4_ff, pwr4_ff;
   logic [PROB_W-1:0]  ph4_ff;
   logic [GAIN_W-1:0]  gain4_ff;

   // stage 5
   logic [39:0]        thr5;
   logic [PROB_W-1:0]  psum5;
   logic               present5_ff, present5_in;
   logic [PROB_W-1:0]  p5_ff, p5_in;
   logic [POWER_W-1:0] s5_ff, mn5_ff, noise5_ff, pwr5_ff;

   // stage 6
   logic [28:0]        ap6;
   logic [PROB_W-1:0]  asum6;
   logic [PROB_W-1:0]  a6_ff, a6_in, p6_ff;
   logic               present6_ff;
   logic [POWER_W-1:0] s6_ff, mn6_ff, noise6_ff, pwr6_ff;

   // stage 7
   logic [48:0]        n1_7_ff, n1_7_in, n2_7_ff, n2_7_in;
   logic [PROB_W-1:0]  p7_ff;
   logic               present7_ff;
   logic [POWER_W-1:0] s7_ff, mn7_ff;

   logic [49:0]        nsum;
   logic [POWER_W-1:0] noise_new;

   // tag shift
   always_comb begin
      vld_in    = {vld_ff[PIPE_DEPTH-2:0], issue};
      inr_in    = {inr_ff[PIPE_DEPTH-2:0], issue_in_range};
      bin_in[0] = issue_req.bin;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         bin_in[i] = bin_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inr_ff <= inr_in;
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            bin_ff[i] <= bin_in[i];
         end
      end
   end

   always_comb begin
      probe_hit = 1'b0;
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         if (vld_ff[i] && inr_ff[i] && (bin_ff[i] == probe_bin)) begin
            probe_hit = 1'b1;
         end
      end
   end

   // arithmetic
   always_comb begin
      m_sp1_in = 48'(rd_data.smooth) * 48'(C_SMOOTH_PREV);
      m_pw1_in = 48'(pwr0_ff) * 48'(C_SMOOTH_CUR);
      m_bt1_in = 48'(rd_data.smooth) * 48'(C_BETA);
      m_gm1_in = 48'(rd_data.minimum) * 48'(C_GAMMA);
      m_ap1_in = 33'(rd_data.presence) * 33'(C_AP_PREV);

      s_sum    = m_sp1_ff + m_pw1_ff;
      s2_in    = s_sum[47:16];
      beta2_in = m_bt1_ff[47:16];
      ph2_in   = m_ap1_ff[32:16];

      rise3_in = min2_ff < s2_ff;
      d3       = $signed({1'b0, s2_ff}) - $signed({1'b0, beta2_ff});
      md3_in   = 44'(d3) * 44'(C_MIN_GAIN);

      v4 = $signed({2'b00, m_gm3_ff}) + 50'(md3_ff);
      if (!rise3_ff) begin
         mn4_in = s3_ff;
      end else if (v4[49]) begin
         mn4_in = '0;
      end else if (v4[48]) begin
         mn4_in = '1;
      end else begin
         mn4_in = v4[47:16];
      end

      thr5        = 40'(gain4_ff) * 40'(mn4_ff);
      present5_in = {4'b0000, s4_ff, 4'b0000} > thr5;
      psum5       = ph4_ff + (present5_in ? C_AP_CUR : '0);
      p5_in       = (psum5 > PROB_ONE) ? PROB_ONE : psum5;

      ap6   = 29'(C_AD_SLOPE) * 29'(p5_ff);
      asum6 = C_AD_BASE + 17'(ap6[28:16]);
      a6_in = (asum6 > PROB_ONE) ? PROB_ONE : asum6;

      n1_7_in = 49'(a6_ff) * 49'(noise6_ff);
      n2_7_in = 49'(PROB_ONE - a6_ff) * 49'(pwr6_ff);

      nsum      = 50'(n1_7_ff) + 50'(n2_7_ff);
      noise_new = (|nsum[49:48]) ? '1 : nsum[47:16];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pwr0_ff  <= issue_req.power;
         gain0_ff <= issue_gain;

         m_sp1_ff  <= m_sp1_in;
         m_pw1_ff  <= m_pw1_in;
         m_bt1_ff  <= m_bt1_in;
         m_gm1_ff  <= m_gm1_in;
         m_ap1_ff  <= m_ap1_in;
         min1_ff   <= rd_data.minimum;
         noise1_ff <= rd_data.noise;
         pwr1_ff   <= pwr0_ff;
         gain1_ff  <= gain0_ff;

         s2_ff     <= s2_in;
         beta2_ff  <= beta2_in;
         ph2_ff    <= ph2_in;
         m_gm2_ff  <= m_gm1_ff;
         min2_ff   <= min1_ff;
         noise2_ff <= noise1_ff;
         pwr2_ff   <= pwr1_ff;
         gain2_ff  <= gain1_ff;

         md3_ff    <= md3_in;
         rise3_ff  <= rise3_in;
         s3_ff     <= s2_ff;
         ph3_ff    <= ph2_ff;
         m_gm3_ff  <= m_gm2_ff;
         noise3_ff <= noise2_ff;
         pwr3_ff   <= pwr2_ff;
         gain3_ff  <= gain2_ff;

         mn4_ff    <= mn4_in;
         s4_ff     <= s3_ff;
         ph4_ff    <= ph3_ff;
         noise4_ff <= noise3_ff;
         pwr4_ff   <= pwr3_ff;
         gain4_ff  <= gain3_ff;

         present5_ff <= present5_in;
         p5_ff       <= p5_in;
         s5_ff       <= s4_ff;
         mn5_ff      <= mn4_ff;
         noise5_ff   <= noise4_ff;
         pwr5_ff     <= pwr4_ff;

         a6_ff       <= a6_in;
         p6_ff       <= p5_ff;
         present6_ff <= present5_ff;
         s6_ff       <= s5_ff;
         mn6_ff      <= mn5_ff;
         noise6_ff   <= noise5_ff;
         pwr6_ff     <= pwr5_ff;

         n1_7_ff     <= n1_7_in;
         n2_7_ff     <= n2_7_in;
         p7_ff       <= p6_ff;
         present7_ff <= present6_ff;
         s7_ff       <= s6_ff;
         mn7_ff      <= mn6_ff;
      end
   end

   // write back and result
   always_comb begin
      wr_en            = advance && vld_ff[PIPE_DEPTH-1] && inr_ff[PIPE_DEPTH-1];
      wr_bin           = bin_ff[PIPE_DEPTH-1];
      wr_data.smooth   = s7_ff;
      wr_data.minimum  = mn7_ff;
      wr_data.presence = p7_ff;
      wr_data.noise    = noise_new;

      res_valid   = vld_ff[PIPE_DEPTH-1];
      res.out_bin = bin_ff[PIPE_DEPTH-1];
      if (inr_ff[PIPE_DEPTH-1]) begin
         res.noise_estimate = noise_new;
         res.speech_prob    = p7_ff;
         res.speech_present = present7_ff;
      end else begin
         res.noise_estimate = '0;
         res.speech_prob    = '0;
         res.speech_present = 1'b0;
      end
   end

   prob_bounded: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res.speech_prob <= PROB_ONE)
      else $error("speech probability above one");

   present_sets_prob: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.speech_present) |-> res.speech_prob >= C_AP_CUR)
      else $error("presence flag without probability step");

   write_has_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> res_valid)
      else $error("write-back without a result");

endmodule

// ===== hdl/loizou_noise_spectrum_tracker.sv =====
// channel   | direction | handshake            | payload
// req_      | in        | req_valid/req_stall  | bin, power
// rsp_      | out       | rsp_valid/rsp_stall  | out_bin, noise_estimate, speech_prob,
//           |           |                      | speech_present
// csr_      | in        | csr_wr_en            | csr_index, csr_wdata
//
// one request per cycle while not stalled, result registered after an 8-stage
// read-modify-write pipeline around one state memory plus output register
// an in-range request whose bin is still in the pipeline waits until that bin
// is written back
// after reset all HALF_BINS+1 state memory entries are cleared, requests stall
// rsp_stall freezes the pipeline once the output register is full
module loizou_noise_spectrum_tracker #(
   parameter int HALF_BINS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nst_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nst_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [nst_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nst_pkg::CSR_W-1:0]           csr_wdata
);

   import nst_pkg::*;

   localparam int DEPTH = HALF_BINS + 1;
   localparam int AW    = $clog2(DEPTH);

   logic [BIN_W-1:0]  low_edge_bin_ff, mid_edge_bin_ff;
   logic [GAIN_W-1:0] low_band_gain_ff, mid_band_gain_ff, high_band_gain_ff;

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] sweep_cnt_ff, sweep_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_payload_ff;

   logic          advance, accept, in_range, hazard;
   logic [GAIN_W-1:0] gain;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   state_type     ram_wdata, ram_rdata;

   logic          upd_wr_en;
   logic [BIN_W-1:0] upd_wr_bin;
   state_type     upd_wr_data;
   logic          upd_res_valid;
   rsp_type       upd_res;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         low_edge_bin_ff   <= RESET_LOW_EDGE;
         mid_edge_bin_ff   <= RESET_MID_EDGE;
         low_band_gain_ff  <= RESET_LOW_GAIN;
         mid_band_gain_ff  <= RESET_MID_GAIN;
         high_band_gain_ff <= RESET_HIGH_GAIN;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_EDGE:  low_edge_bin_ff   <= csr_wdata;
            CSR_MID_EDGE:  mid_edge_bin_ff   <= csr_wdata;
            CSR_LOW_GAIN:  low_band_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_MID_GAIN:  mid_band_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_HIGH_GAIN: high_band_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // band threshold, high band wins
   always_comb begin
      priority if (req_payload.bin >= mid_edge_bin_ff) begin
         gain = high_band_gain_ff;
      end else if (req_payload.bin <= low_edge_bin_ff) begin
         gain = low_band_gain_ff;
      end else begin
         gain = mid_band_gain_ff;
      end
   end

   // clearing sweep and handshake
   always_comb begin
      in_range  = 32'(req_payload.bin) <= 32'(HALF_BINS);
      advance   = !rsp_valid_ff || !rsp_stall;
      req_stall = clearing_ff || !advance || (in_range && hazard);
      accept    = req_valid && !req_stall;

      clearing_in  = clearing_ff && (sweep_cnt_ff != AW'(HALF_BINS));
      sweep_cnt_in = clearing_ff ? sweep_cnt_ff + 1'b1 : sweep_cnt_ff;

      ram_re    = accept && in_range;
      ram_raddr = AW'(req_payload.bin);
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = sweep_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = upd_wr_en;
         ram_waddr = AW'(upd_wr_bin);
         ram_wdata = upd_wr_data;
      end

      rsp_valid_in = advance ? upd_res_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= upd_res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   nst_ram #(
      .WIDTH (STATE_W),
      .DEPTH (DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   nst_update u_update (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .issue          (accept),
      .issue_in_range (in_range),
      .issue_req      (req_payload),
      .issue_gain     (gain),
      .rd_data        (ram_rdata),
      .probe_bin      (req_payload.bin),
      .probe_hit      (hazard),
      .wr_en          (upd_wr_en),
      .wr_bin         (upd_wr_bin),
      .wr_data        (upd_wr_data),
      .res_valid      (upd_res_valid),
      .res            (upd_res)
   );

   no_update_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !upd_wr_en)
      else $error("pipeline write during memory clear");

   sweep_covers_all: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(sweep_cnt_ff) == AW'(HALF_BINS))
      else $error("memory clear ended early");

   no_read_of_pending_bin: assert property (@(posedge clock) disable iff (reset)
      (ram_re && upd_wr_en) |-> ram_raddr != ram_waddr)
      else $error("read of a bin with write-back pending");

endmodule

// ===== verif/tb_loizou_noise_spectrum_tracker.sv =====
module tb_loizou_noise_spectrum_tracker;
   import nst_pkg::*;

   localparam int HALF_BINS      = 1024;
   localparam int BIN_MAX        = 2**BIN_W - 1;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 232;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   localparam longint unsigned K_SMOOTH_KEEP = 45875;
   localparam longint unsigned K_SMOOTH_NEW  = 19661;
   localparam longint unsigned K_FLOOR_KEEP  = 65405;
   localparam longint          K_FLOOR_RISE  = 655;
   localparam longint unsigned K_DECAY       = 52429;
   localparam longint unsigned K_PROB_KEEP   = 13107;
   localparam longint unsigned K_PROB_SPEECH = 52429;
   localparam longint unsigned K_ALPHA_BASE  = 62259;
   localparam longint unsigned K_ALPHA_SLOPE = 3277;
   localparam longint unsigned PROB_FULL     = 65536;
   localparam longint unsigned POWER_MAX     = 64'hFFFF_FFFF;

   class tracker_scoreboard;
      logic [POWER_W-1:0] smooth_pow [0:HALF_BINS];
      logic [POWER_W-1:0] min_pow    [0:HALF_BINS];
      logic [PROB_W-1:0]  speech_p   [0:HALF_BINS];
      logic [POWER_W-1:0] noise_pow  [0:HALF_BINS];
      logic [BIN_W-1:0]   low_edge, mid_edge;
      logic [GAIN_W-1:0]  low_gain, mid_gain, high_gain;
      rsp_type            results_due [$];
      int                 errors;

      function new();
         foreach (smooth_pow[i]) begin
            smooth_pow[i] = '0;
            min_pow[i]    = '0;
            speech_p[i]   = '0;
            noise_pow[i]  = '0;
         end
         low_edge  = RESET_LOW_EDGE;
         mid_edge  = RESET_MID_EDGE;
         low_gain  = RESET_LOW_GAIN;
         mid_gain  = RESET_MID_GAIN;
         high_gain = RESET_HIGH_GAIN;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_LOW_EDGE:  low_edge  = value[BIN_W-1:0];
            CSR_MID_EDGE:  mid_edge  = value[BIN_W-1:0];
            CSR_LOW_GAIN:  low_gain  = value[GAIN_W-1:0];
            CSR_MID_GAIN:  mid_gain  = value[GAIN_W-1:0];
            CSR_HIGH_GAIN: high_gain = value[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void note_request(req_type rq);
         rsp_type rs;
         longint unsigned prev_s, prev_m, prev_p, prev_n, pw, s, m, p, a, n, g;
         longint v;
         bit present;
         rs = '0;
         rs.out_bin = rq.bin;
         if (rq.bin > HALF_BINS) begin
            results_due.push_back(rs);
            return;
         end
         prev_s = smooth_pow[rq.bin];
         prev_m = min_pow[rq.bin];
         prev_p = speech_p[rq.bin];
         prev_n = noise_pow[rq.bin];
         pw = rq.power;
         s = (K_SMOOTH_KEEP * prev_s + K_SMOOTH_NEW * pw) >> 16;
         if (prev_m < s) begin
            v = longint'(K_FLOOR_KEEP * prev_m)
                + K_FLOOR_RISE * (longint'(s) - longint'((K_DECAY * prev_s) >> 16));
            if (v < 0) begin
               m = 0;
            end else begin
               m = v >>> 16;
            end
            if (m > POWER_MAX) m = POWER_MAX;
         end else begin
            m = s;
         end
         if (rq.bin >= mid_edge) begin
            g = high_gain;
         end else if (rq.bin <= low_edge) begin
            g = low_gain;
         end else begin
            g = mid_gain;
         end
         present = (s << 4) > g * m;
         p = ((K_PROB_KEEP * prev_p) >> 16) + (present ? K_PROB_SPEECH : 64'd0);
         if (p > PROB_FULL) p = PROB_FULL;
         a = K_ALPHA_BASE + ((K_ALPHA_SLOPE * p) >> 16);
         if (a > PROB_FULL) a = PROB_FULL;
         n = (a * prev_n + (PROB_FULL - a) * pw) >> 16;
         if (n > POWER_MAX) n = POWER_MAX;
         smooth_pow[rq.bin] = s[POWER_W-1:0];
         min_pow[rq.bin]    = m[POWER_W-1:0];
         speech_p[rq.bin]   = p[PROB_W-1:0];
         noise_pow[rq.bin]  = n[POWER_W-1:0];
         rs.noise_estimate = n[POWER_W-1:0];
         rs.speech_prob    = p[PROB_W-1:0];
         rs.speech_present = present;
         results_due.push_back(rs);
      endfunction

      function void compare(string field, logic [POWER_W-1:0] want, logic [POWER_W-1:0] got);
         if (got !== want) begin
            $error("%s expected %0d got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            $error("response for bin %0d with nothing outstanding", got.out_bin);
            errors++;
            return;
         end
         want = results_due.pop_front();
         compare("out_bin", want.out_bin, got.out_bin);
         compare("noise_estimate", want.noise_estimate, got.noise_estimate);
         compare("speech_prob", want.speech_prob, got.speech_prob);
         compare("speech_present", want.speech_present, got.speech_present);
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b1;
   rsp_type                rsp_payload;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_W-1:0]       csr_wdata   = '0;

   tracker_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  sender_gaps = 1'b0;
   bit  hold_output = 1'b0;

   loizou_noise_spectrum_tracker #(.HALF_BINS(HALF_BINS)) dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
      if (!reset && req_valid && !req_stall) sb.note_request(req_payload);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("loizou_noise_spectrum_tracker test failed");
      $finish;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [POWER_W-1:0] shape_power(logic [POWER_W-1:0] level);
      longint unsigned v;
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = 64'(level) + $urandom_range(0, level >> 2);
      end else if (r < 75) begin
         v = 64'(level) * $urandom_range(8, 64);
      end else if (r < 88) begin
         v = level / $urandom_range(2, 16);
      end else if (r < 92) begin
         v = 0;
      end else begin
         v = $urandom;
      end
      if (v > POWER_MAX) v = POWER_MAX;
      return v[POWER_W-1:0];
   endfunction

   initial begin : receiver
      bit rsp_gaps;
      rsp_gaps = 1'b1;
      while (reset) @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            if ($urandom_range(0, 19) == 0) rsp_gaps = !rsp_gaps;
            rsp_stall <= rsp_gaps && ($urandom_range(0, 2) == 0);
            repeat (idle_length()) @(posedge clock);
         end
      end
   end

   task automatic send_request(logic [BIN_W-1:0] bin_idx, logic [POWER_W-1:0] pw);
      int gap;
      req_valid <= 1'b1;
      req_payload <= '{bin: bin_idx, power: pw};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = (sender_gaps && $urandom_range(0, 1) == 1) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic apply_settings(logic [CSR_W-1:0] low_edge, mid_edge, low_gain, mid_gain,
                                 high_gain);
      write_reg(CSR_LOW_EDGE, low_edge);
      write_reg(CSR_MID_EDGE, mid_edge);
      write_reg(CSR_LOW_GAIN, low_gain);
      write_reg(CSR_MID_GAIN, mid_gain);
      write_reg(CSR_HIGH_GAIN, high_gain);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_traffic(int count);
      logic [BIN_W-1:0]   hot_bin [8];
      logic [POWER_W-1:0] hot_level [8];
      int r, slot;
      hot_bin[0] = '0;
      hot_bin[1] = BIN_W'(HALF_BINS);
      hot_bin[2] = sb.low_edge;
      hot_bin[3] = sb.low_edge + 1'b1;
      hot_bin[4] = sb.mid_edge - 1'b1;
      hot_bin[5] = sb.mid_edge;
      hot_bin[6] = BIN_W'($urandom_range(0, HALF_BINS));
      hot_bin[7] = BIN_W'($urandom_range(0, HALF_BINS));
      foreach (hot_level[i]) begin
         case ($urandom_range(0, 2))
            0: hot_level[i] = $urandom_range(1, 300);
            1: hot_level[i] = $urandom_range(1000, 2000000);
            default: hot_level[i] = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
         endcase
      end
      repeat (count) begin
         if ($urandom_range(0, 49) == 0) sender_gaps = !sender_gaps;
         r = $urandom_range(0, 99);
         slot = $urandom_range(0, 7);
         if (r < 75) begin
            send_request(hot_bin[slot], shape_power(hot_level[slot]));
         end else if (r < 92) begin
            send_request(BIN_W'($urandom_range(0, HALF_BINS)), shape_power(hot_level[slot]));
         end else begin
            send_request(BIN_W'($urandom_range(HALF_BINS + 1, BIN_MAX)), $urandom);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: fresh bins, full scale, band edges, out-of-range bins
      send_request(0, 0);
      repeat (4) send_request(0, 32'hFFFF_FFFF);
      send_request(BIN_W'(HALF_BINS), 32'hFFFF_FFFF);
      send_request(BIN_W'(HALF_BINS + 1), 12345);
      send_request(BIN_W'(BIN_MAX), 32'hFFFF_FFFF);
      send_request(43, 5000);
      send_request(44, 5000);
      send_request(127, 5000);
      send_request(128, 5000);
      // small powers keep the minimum at zero; a drop makes its update negative
      repeat (3) send_request(7, 100);
      repeat (2) send_request(7, 0);
      send_request(1, 1);
      send_request(1, 0);
      send_request(11'h2AA, 32'hAAAA_AAAA);
      send_request(11'h155, 32'h5555_5555);
      req_valid <= 1'b0;

      sender_gaps = 1'b1;
      run_traffic(PHASE_ITEMS);
      wait_drained();

      apply_settings(0, 0, 0, 0, 0);
      run_traffic(PHASE_ITEMS);
      wait_drained();

      // output held off while requests keep coming
      apply_settings(CSR_W'(HALF_BINS), CSR_W'(HALF_BINS), 255, 255, 255);
      sender_gaps = 1'b0;
      hold_output = 1'b1;
      run_traffic(PHASE_ITEMS);
      wait_drained();

      apply_settings(500, 200, CSR_W'($urandom_range(0, 255)), CSR_W'($urandom_range(0, 255)),
                     CSR_W'($urandom_range(0, 255)));
      sender_gaps = 1'b1;
      run_traffic(PHASE_ITEMS);
      wait_drained();

      apply_settings(CSR_W'($urandom_range(0, HALF_BINS)), CSR_W'($urandom_range(0, HALF_BINS)),
                     CSR_W'($urandom_range(0, BIN_MAX)), CSR_W'($urandom_range(0, BIN_MAX)),
                     CSR_W'($urandom_range(0, BIN_MAX)));
      run_traffic(PHASE_ITEMS);
      wait_drained();

      write_reg(CSR_SPARE, CSR_W'($urandom_range(0, BIN_MAX)));
      apply_settings(RESET_LOW_EDGE, RESET_MID_EDGE, CSR_W'(RESET_LOW_GAIN),
                     CSR_W'(RESET_MID_GAIN), CSR_W'(RESET_HIGH_GAIN));
      run_traffic(PHASE_ITEMS);
      wait_drained();

      apply_settings(CSR_W'($urandom_range(0, HALF_BINS)), CSR_W'($urandom_range(0, HALF_BINS)),
                     CSR_W'($urandom_range(0, 255)), CSR_W'($urandom_range(0, 255)),
                     CSR_W'($urandom_range(0, 255)));
      run_traffic(PHASE_ITEMS);
      wait_drained();

      repeat (2 * PIPE_DEPTH + 4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("loizou_noise_spectrum_tracker test passed");
      end else begin
         $display("loizou_noise_spectrum_tracker test failed");
      end
      $finish;
   end

endmodule
